@@ design/round_robin_event_router_defines.svh @@
// ----------------------------------------------------------------------------
// round robin event router assertion macros
// shared property forms used by the port checker
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_EVENT_ROUTER_DEFINES_SVH
`define ROUND_ROBIN_EVENT_ROUTER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RRER_ASSERT_NOW(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("round robin event router check failed");

// next-cycle implication, checked outside reset
`define RRER_ASSERT_NEXT(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("round robin event router check failed");

`endif

@@ design/rrer_pkg.sv @@
// ----------------------------------------------------------------------------
// rrer_pkg
// field widths, status codes and register indexes of the event router
// ----------------------------------------------------------------------------
`default_nettype none

package rrer_pkg;

  // item field widths
  localparam int SRC_ID_W    = 3;
  localparam int DEST_ID_W   = 4;
  localparam int PAYLOAD_W   = 32;
  localparam int STATUS_W    = 3;

  // configuration register widths
  localparam int SRC_MASK_W  = 8;
  localparam int DEST_MASK_W = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  // parameter defaults
  localparam int DEF_NUM_SOURCES   = 8;
  localparam int DEF_QUEUE_DEPTH   = 16;
  localparam int DEF_NUM_DESTS     = 16;
  localparam int DEF_PAYLOAD_WIDTH = 32;

  // item function codes
  localparam logic FUNC_PUSH  = 1'b0;
  localparam logic FUNC_ROUTE = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_PUSHED      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN_SRC = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL        = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ROUTED      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DISCARDED   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NONE        = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_ENABLE   = 2'd1;

endpackage

`default_nettype wire

@@ design/rrer_if.sv @@
// ----------------------------------------------------------------------------
// rrer channel interfaces
// event input, result output and configuration write channels
// ----------------------------------------------------------------------------
`default_nettype none

// event input channel
interface rrer_in_if;
  logic                           valid;
  logic                           ready;
  logic                           func;
  logic [rrer_pkg::SRC_ID_W-1:0]  source_id;
  logic [rrer_pkg::DEST_ID_W-1:0] dest_id;
  logic [rrer_pkg::PAYLOAD_W-1:0] payload;

  modport source (output valid, func, source_id, dest_id, payload, input ready);
  modport sink (input valid, func, source_id, dest_id, payload, output ready);
endinterface

// result output channel
interface rrer_out_if;
  logic                           valid;
  logic                           ready;
  logic [rrer_pkg::STATUS_W-1:0]  status;
  logic [rrer_pkg::SRC_ID_W-1:0]  out_source;
  logic [rrer_pkg::DEST_ID_W-1:0] out_dest;
  logic [rrer_pkg::PAYLOAD_W-1:0] out_payload;

  modport source (output valid, status, out_source, out_dest, out_payload, input ready);
  modport sink (input valid, status, out_source, out_dest, out_payload, output ready);
endinterface

// configuration write channel
interface rrer_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [rrer_pkg::CFG_IDX_W-1:0]  index;
  logic [rrer_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ design/rrer_arb.sv @@
// ----------------------------------------------------------------------------
// rrer_arb
// rotating priority pick of the next eligible source after the pointer
// ----------------------------------------------------------------------------
`default_nettype none

module rrer_arb #(
  parameter int NUM_SOURCES = rrer_pkg::DEF_NUM_SOURCES,
  localparam int SW = $clog2(NUM_SOURCES)
) (
  input  wire logic [NUM_SOURCES-1:0] eligible,
  input  wire logic [SW-1:0]          ptr,
  output logic                        found,
  output logic [SW-1:0]               sel
);

  logic [NUM_SOURCES-1:0] upper;
  logic [SW-1:0]          sel_upper;
  logic [SW-1:0]          sel_any;

  // sources at or after the pointer
  always_comb begin
    for (int i = 0; i < NUM_SOURCES; i++) begin
      upper[i] = eligible[i] && (i >= int'(ptr));
    end
  end

  // lowest set bit of each vector
  always_comb begin
    sel_upper = '0;
    sel_any   = '0;
    for (int i = NUM_SOURCES - 1; i >= 0; i--) begin
      if (upper[i]) begin
        sel_upper = SW'(i);
      end
      if (eligible[i]) begin
        sel_any = SW'(i);
      end
    end
  end

  // wrap to the start when nothing is left after the pointer
  assign found = |eligible;
  assign sel   = (|upper) ? sel_upper : sel_any;

endmodule

`default_nettype wire

@@ design/round_robin_event_router.sv @@
// ----------------------------------------------------------------------------
// round_robin_event_router
// per-source event queues served in round-robin order
// ----------------------------------------------------------------------------
// Takes one item per clock cycle while the result channel is not stalled and
// returns exactly one result for each. The result passes through the input
// register and the result register before it shows on the result channel. A
// push appends a (destination, payload) event to its source's queue; a route
// pops the oldest event of the next enabled, non-empty source after the last
// one served and forwards it, or discards it if its destination is not
// enabled. All queues share one memory with one write and one registered read
// port; a transaction touches that memory once, which is what sets the rate
// of one item per cycle. A stalled result holds the input in the same cycle.
// Pointers and fill counts live in flip-flops and clear at reset, so no
// clearing pass is needed. Configuration writes are accepted in every cycle
// and must only be made while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module round_robin_event_router #(
  parameter int NUM_SOURCES   = rrer_pkg::DEF_NUM_SOURCES,
  parameter int QUEUE_DEPTH   = rrer_pkg::DEF_QUEUE_DEPTH,
  parameter int NUM_DESTS     = rrer_pkg::DEF_NUM_DESTS,
  parameter int PAYLOAD_WIDTH = rrer_pkg::DEF_PAYLOAD_WIDTH
) (
  input  wire logic clk,
  input  wire logic rst,
  rrer_in_if.sink   ev_in,
  rrer_out_if.source ev_out,
  rrer_cfg_if.sink  cfg
);

  import rrer_pkg::*;

  localparam int SW    = $clog2(NUM_SOURCES);
  localparam int HW    = $clog2(QUEUE_DEPTH);
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int AW    = $clog2(NUM_SOURCES * QUEUE_DEPTH);
  localparam int DEPTH = NUM_SOURCES * QUEUE_DEPTH;
  localparam int EW    = DEST_ID_W + PAYLOAD_WIDTH;

  // configuration registers
  logic [SRC_MASK_W-1:0]  src_mask;
  logic [DEST_MASK_W-1:0] dest_mask;

  // queue bookkeeping
  logic [HW-1:0] heads [NUM_SOURCES];
  logic [HW-1:0] tails [NUM_SOURCES];
  logic [CW-1:0] counts [NUM_SOURCES];
  logic [SW-1:0] rr_ptr;

  // event memory
  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rdata;

  // input register
  logic                 s1_valid;
  logic                 s1_func;
  logic [SRC_ID_W-1:0]  s1_src;
  logic [DEST_ID_W-1:0] s1_dest;
  logic [PAYLOAD_W-1:0] s1_payload;

  // result register
  logic                 s2_valid;
  logic                 s2_popped;
  logic [STATUS_W-1:0]  s2_status;
  logic [SRC_ID_W-1:0]  s2_src;

  // stage 1 decode
  logic                   adv;
  logic [NUM_SOURCES-1:0] src_en;
  logic [NUM_SOURCES-1:0] eligible;
  logic [NUM_SOURCES-1:0] full;
  logic [SW-1:0]          push_idx;
  logic                   push_known;
  logic                   push_ok;
  logic                   pop_found;
  logic [SW-1:0]          pop_sel;
  logic                   pop_ok;
  logic [STATUS_W-1:0]    s1_status;
  logic [AW-1:0]          waddr;
  logic [AW-1:0]          raddr;

  // stage 2 decode
  logic [DEST_ID_W-1:0]     rd_dest;
  logic [PAYLOAD_WIDTH-1:0] rd_payload;
  logic                     dest_ok;

  // both stages move together, a stalled result holds the input
  assign adv         = !s2_valid || ev_out.ready;
  assign ev_in.ready = adv;
  assign cfg.ready   = 1'b1;

  // per-source enable and occupancy flags
  always_comb begin
    for (int s = 0; s < NUM_SOURCES; s++) begin
      src_en[s]   = (s < SRC_MASK_W) ? src_mask[s % SRC_MASK_W] : 1'b0;
      full[s]     = (counts[s] == CW'(QUEUE_DEPTH));
      eligible[s] = src_en[s] && (counts[s] != '0);
    end
  end

  rrer_arb #(
    .NUM_SOURCES(NUM_SOURCES)
  ) u_arb (
    .eligible(eligible),
    .ptr     (rr_ptr),
    .found   (pop_found),
    .sel     (pop_sel)
  );

  // push checks and status
  always_comb begin
    push_idx   = SW'(s1_src);
    push_known = (int'(s1_src) < NUM_SOURCES) && src_en[push_idx];
    push_ok    = s1_valid && (s1_func == FUNC_PUSH) && push_known && !full[push_idx];
    pop_ok     = s1_valid && (s1_func == FUNC_ROUTE) && pop_found;
    if (s1_func == FUNC_ROUTE) begin
      s1_status = ST_NONE;
    end else if (!push_known) begin
      s1_status = ST_UNKNOWN_SRC;
    end else if (full[push_idx]) begin
      s1_status = ST_FULL;
    end else begin
      s1_status = ST_PUSHED;
    end
  end

  // memory addresses: queue base plus slot
  assign waddr = AW'(push_idx) * AW'(QUEUE_DEPTH) + AW'(tails[push_idx]);
  assign raddr = AW'(pop_sel) * AW'(QUEUE_DEPTH) + AW'(heads[pop_sel]);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      src_mask  <= '0;
      dest_mask <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_SOURCE_ENABLE: src_mask  <= cfg.data[SRC_MASK_W-1:0];
        REG_DEST_ENABLE:   dest_mask <= cfg.data[DEST_MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= ev_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_func    <= ev_in.func;
      s1_src     <= ev_in.source_id;
      s1_dest    <= ev_in.dest_id;
      s1_payload <= ev_in.payload;
    end
  end

  // queue pointers, fill counts and round-robin pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      rr_ptr <= '0;
      for (int s = 0; s < NUM_SOURCES; s++) begin
        heads[s]  <= '0;
        tails[s]  <= '0;
        counts[s] <= '0;
      end
    end else if (adv) begin
      if (push_ok) begin
        tails[push_idx]  <= (tails[push_idx] == HW'(QUEUE_DEPTH - 1)) ?
                            '0 : tails[push_idx] + 1'b1;
        counts[push_idx] <= counts[push_idx] + 1'b1;
      end
      if (pop_ok) begin
        heads[pop_sel]  <= (heads[pop_sel] == HW'(QUEUE_DEPTH - 1)) ?
                           '0 : heads[pop_sel] + 1'b1;
        counts[pop_sel] <= counts[pop_sel] - 1'b1;
        rr_ptr          <= (pop_sel == SW'(NUM_SOURCES - 1)) ? '0 : pop_sel + 1'b1;
      end
    end
  end

  // event memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (adv && push_ok) begin
      mem[waddr] <= {s1_dest, PAYLOAD_WIDTH'(s1_payload)};
    end
    if (adv) begin
      rdata <= mem[raddr];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_popped <= pop_ok;
      s2_status <= s1_status;
      s2_src    <= pop_ok ? SRC_ID_W'(pop_sel) : '0;
    end
  end

  // destination check on the popped event
  assign rd_dest    = rdata[EW-1 -: DEST_ID_W];
  assign rd_payload = rdata[PAYLOAD_WIDTH-1:0];
  assign dest_ok    = (int'(rd_dest) < NUM_DESTS) && dest_mask[rd_dest];

  // result fields
  always_comb begin
    ev_out.valid      = s2_valid;
    ev_out.out_source = s2_src;
    if (s2_popped) begin
      ev_out.status      = dest_ok ? ST_ROUTED : ST_DISCARDED;
      ev_out.out_dest    = rd_dest;
      ev_out.out_payload = dest_ok ? PAYLOAD_W'(rd_payload) : '0;
    end else begin
      ev_out.status      = s2_status;
      ev_out.out_dest    = '0;
      ev_out.out_payload = '0;
    end
  end

endmodule

`default_nettype wire

@@ design/rrer_checker.sv @@
// ----------------------------------------------------------------------------
// rrer_checker
// port-level checks on the result channel of the event router
// ----------------------------------------------------------------------------
`default_nettype none

`include "round_robin_event_router_defines.svh"

module rrer_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [rrer_pkg::STATUS_W-1:0]  status,
  input wire logic [rrer_pkg::SRC_ID_W-1:0]  out_source,
  input wire logic [rrer_pkg::DEST_ID_W-1:0] out_dest,
  input wire logic [rrer_pkg::PAYLOAD_W-1:0] out_payload
);

  import rrer_pkg::*;

  logic no_event;

  // results that carry no popped event
  assign no_event = (status == ST_PUSHED) || (status == ST_UNKNOWN_SRC) ||
                    (status == ST_FULL) || (status == ST_NONE);

  // a stalled result holds its status
  `RRER_ASSERT_NEXT(a_stall_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(status))

  // only defined status codes leave the block
  `RRER_ASSERT_NOW(a_status_range, clk, rst, out_valid, status <= ST_NONE)

  // payload is only carried by routed events
  `RRER_ASSERT_NOW(a_payload_zero, clk, rst, out_valid && status != ST_ROUTED, out_payload == '0)

  // push and empty results name no source or destination
  `RRER_ASSERT_NOW(a_ids_zero, clk, rst, out_valid && no_event, out_source == '0 && out_dest == '0)

endmodule

bind round_robin_event_router rrer_checker u_rrer_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (ev_out.valid),
  .out_ready  (ev_out.ready),
  .status     (ev_out.status),
  .out_source (ev_out.out_source),
  .out_dest   (ev_out.out_dest),
  .out_payload(ev_out.out_payload)
);

`default_nettype wire

@@ verif/rrer_route_checker.sv @@
// ----------------------------------------------------------------------------
// rrer_route_checker
// Watches the event, result and register channels of the event router,
// keeps its own copy of the per-source queues, masks and round-robin
// pointer, and checks every returned result against the oldest
// outstanding prediction.
// ----------------------------------------------------------------------------
module rrer_route_checker
  import rrer_pkg::*;
(
  input  logic clk,
  input  logic rst,
  rrer_in_if   ev_in,
  rrer_out_if  ev_out,
  rrer_cfg_if  cfg,
  output int   fail_count,
  output int   outstanding
);

  localparam int NSRC   = DEF_NUM_SOURCES;
  localparam int QDEPTH = DEF_QUEUE_DEPTH;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [SRC_ID_W-1:0]  src;
    logic [DEST_ID_W-1:0] dest;
    logic [PAYLOAD_W-1:0] payload;
  } router_result_t;

  // shadow of the queue memory, pointers and registers
  logic [DEST_ID_W-1:0] ev_dest    [NSRC][QDEPTH];
  logic [PAYLOAD_W-1:0] ev_payload [NSRC][QDEPTH];
  logic [3:0]           q_head     [NSRC];
  logic [4:0]           q_fill     [NSRC];
  logic [SRC_ID_W-1:0]  serve_ptr;
  logic [SRC_MASK_W-1:0]  src_enable;
  logic [DEST_MASK_W-1:0] dst_enable;

  router_result_t pending_results [$];
  int errors = 0;

  // apply one push or route to the shadow state and return its result
  function automatic router_result_t next_result(input logic func,
                                                 input logic [SRC_ID_W-1:0] src,
                                                 input logic [DEST_ID_W-1:0] dst,
                                                 input logic [PAYLOAD_W-1:0] pay);
    router_result_t      r;
    logic [3:0]          slot;
    logic [SRC_ID_W-1:0] s;
    bit                  found;
    r = '0;
    found = 1'b0;
    if (func == FUNC_PUSH) begin
      if (!src_enable[src]) begin
        r.status = ST_UNKNOWN_SRC;
      end else if (q_fill[src] == 5'(QDEPTH)) begin
        r.status = ST_FULL;
      end else begin
        slot = q_head[src] + q_fill[src][3:0];
        ev_dest[src][slot] = dst;
        ev_payload[src][slot] = pay;
        q_fill[src] = q_fill[src] + 5'd1;
        r.status = ST_PUSHED;
      end
    end else begin
      r.status = ST_NONE;
      // scan from the pointer, first enabled non-empty source wins
      for (int k = 0; k < NSRC; k++) begin
        s = serve_ptr + SRC_ID_W'(k);
        if (!found && src_enable[s] && q_fill[s] != 5'd0) begin
          found = 1'b1;
          r.src = s;
          r.dest = ev_dest[s][q_head[s]];
          if (dst_enable[r.dest]) begin
            r.status = ST_ROUTED;
            r.payload = ev_payload[s][q_head[s]];
          end else begin
            r.status = ST_DISCARDED;
          end
          q_head[s] = q_head[s] + 4'd1;
          q_fill[s] = q_fill[s] - 5'd1;
          serve_ptr = s + SRC_ID_W'(1);
        end
      end
    end
    return r;
  endfunction

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t %s mismatch: expected %0h actual %0h", $time, what, want, got);
      errors++;
    end
  endtask

  // sample all channels at the clock edge
  always @(posedge clk) begin : watch
    router_result_t want;
    if (rst) begin
      for (int i = 0; i < NSRC; i++) begin
        q_head[i] = '0;
        q_fill[i] = '0;
      end
      serve_ptr = '0;
      src_enable = '0;
      dst_enable = '0;
      pending_results.delete();
    end else begin
      // register writes
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_SOURCE_ENABLE: src_enable = cfg.data[SRC_MASK_W-1:0];
          REG_DEST_ENABLE:   dst_enable = cfg.data[DEST_MASK_W-1:0];
          default: ;
        endcase
      end
      // accepted event transaction
      if (ev_in.valid && ev_in.ready) begin
        pending_results.insert(pending_results.size(),
                               next_result(ev_in.func, ev_in.source_id,
                                           ev_in.dest_id, ev_in.payload));
      end
      // accepted result transaction
      if (ev_out.valid && ev_out.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t unexpected result: expected none, actual %0d %0d %0d %h",
                   $time, ev_out.status, ev_out.out_source, ev_out.out_dest,
                   ev_out.out_payload);
          errors++;
        end else begin
          want = pending_results.pop_front();
          check_field("status", 32'(want.status), 32'(ev_out.status));
          check_field("out_source", 32'(want.src), 32'(ev_out.out_source));
          check_field("out_dest", 32'(want.dest), 32'(ev_out.out_dest));
          check_field("out_payload", want.payload, ev_out.out_payload);
        end
      end
    end
    outstanding <= pending_results.size();
    fail_count <= errors;
  end

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Drives the event router with a directed opening and random phases of
// pushes and routes under several source and destination mask settings,
// with random idling on both sides, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import rrer_pkg::*;

  // register indexes past the end of the map, writes there are ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  logic clk;
  logic rst;
  bit   idle_on;
  int   fail_count;
  int   outstanding;

  rrer_in_if  ev_in ();
  rrer_out_if ev_out ();
  rrer_cfg_if cfg ();

  round_robin_event_router DUT (
    .clk    (clk),
    .rst    (rst),
    .ev_in  (ev_in),
    .ev_out (ev_out),
    .cfg    (cfg)
  );

  rrer_route_checker u_route_check (
    .clk         (clk),
    .rst         (rst),
    .ev_in       (ev_in),
    .ev_out      (ev_out),
    .cfg         (cfg),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // result side backpressure in bursts
  initial begin
    ev_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        ev_out.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      ev_out.ready <= 1'b1;
    end
  end

  // hard stop
  initial begin
    #4000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // offer one event transaction, valid stays high for the next one
  task automatic send_item(input logic func, input logic [SRC_ID_W-1:0] src,
                           input logic [DEST_ID_W-1:0] dst,
                           input logic [PAYLOAD_W-1:0] pay);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      ev_in.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    ev_in.valid     <= 1'b1;
    ev_in.func      <= func;
    ev_in.source_id <= src;
    ev_in.dest_id   <= dst;
    ev_in.payload   <= pay;
    do @(posedge clk); while (!ev_in.ready);
  endtask

  // stop offering events and wait for every result to come back
  task automatic wait_drained();
    ev_in.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk); while (!cfg.ready);
  endtask

  // reprogram both masks while idle, with a stray write in between
  task automatic set_masks(input logic [SRC_MASK_W-1:0] src_m,
                           input logic [DEST_MASK_W-1:0] dst_m);
    wait_drained();
    write_reg(REG_SOURCE_ENABLE, {8'($urandom), src_m});
    write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, 16'($urandom));
    write_reg(REG_DEST_ENABLE, dst_m);
    cfg.valid <= 1'b0;
  endtask

  // stimulus
  initial begin : stim
    logic [SRC_MASK_W-1:0]  src_m;
    logic [DEST_MASK_W-1:0] dst_m;
    logic                   f;
    logic [SRC_ID_W-1:0]    s;
    logic [SRC_ID_W-1:0]    hot;
    logic [PAYLOAD_W-1:0]   pay;
    int                     push_pct;
    int                     n_items;

    idle_on = 1'b1;
    rst <= 1'b1;
    ev_in.valid     <= 1'b0;
    ev_in.func      <= FUNC_PUSH;
    ev_in.source_id <= '0;
    ev_in.dest_id   <= '0;
    ev_in.payload   <= '0;
    cfg.valid <= 1'b0;
    cfg.index <= REG_SOURCE_ENABLE;
    cfg.data  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // masks still at reset: unknown source and nothing to route
    send_item(FUNC_PUSH, 3'd0, 4'd0, 32'h0);
    send_item(FUNC_ROUTE, 3'd0, 4'd0, 32'h0);

    // everything enabled: round-robin order across three sources
    set_masks(8'hFF, 16'hFFFF);
    send_item(FUNC_PUSH, 3'd7, 4'd15, 32'hFFFF_FFFF);
    send_item(FUNC_PUSH, 3'd0, 4'd0, 32'h0);
    send_item(FUNC_PUSH, 3'd3, 4'd5, 32'hA5C3_5A3C);
    repeat (4) send_item(FUNC_ROUTE, 3'($urandom), 4'($urandom), $urandom);

    // fill one queue past its depth
    for (int i = 0; i < 17; i++) begin
      send_item(FUNC_PUSH, 3'd1, 4'(i), $urandom);
    end

    // disabled source keeps its events, disabled destination discards
    set_masks(8'h7D, 16'h7FFF);
    send_item(FUNC_PUSH, 3'd1, 4'd3, $urandom);
    send_item(FUNC_ROUTE, 3'd0, 4'd0, 32'h0);
    send_item(FUNC_PUSH, 3'd2, 4'd15, $urandom);
    send_item(FUNC_ROUTE, 3'd0, 4'd0, 32'h0);

    // random phases over a range of mask settings
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin src_m = 8'hFF; dst_m = 16'hFFFF; end
        1: begin src_m = 8'h00; dst_m = 16'($urandom); end
        2: begin src_m = 8'h81; dst_m = 16'h0000; end
        7: begin src_m = 8'hFF; dst_m = 16'hFFFF; end
        default: begin
          src_m = 8'($urandom) | 8'($urandom);
          dst_m = 16'($urandom) | 16'($urandom);
        end
      endcase
      set_masks(src_m, dst_m);
      idle_on  = (p != 4 && p != 7);
      n_items  = (p == 1) ? 40 : 95;
      push_pct = $urandom_range(35, 75);
      hot      = 3'($urandom);
      for (int i = 0; i < n_items; i++) begin
        f = ($urandom_range(0, 99) < push_pct) ? FUNC_PUSH : FUNC_ROUTE;
        s = ($urandom_range(0, 2) == 0) ? hot : 3'($urandom);
        case ($urandom_range(0, 7))
          0:       pay = '0;
          1:       pay = '1;
          default: pay = $urandom;
        endcase
        send_item(f, s, 4'($urandom), pay);
      end
    end

    // drain and let the pipeline settle
    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
